// ===== sv/cvs_pkg.sv =====
package cvs_pkg;

  typedef enum logic [2:0] {
    KindClear   = 3'd0,
    KindSet     = 3'd1,
    KindRead    = 3'd2,
    KindNorm    = 3'd3,
    KindRescale = 3'd4
  } kind_e;

  localparam logic [7:0] OctaveStep = 8'd12;
  localparam logic [7:0] MinSeed    = 8'd127;
  localparam logic [6:0] FoldLimit  = 7'd64;

  typedef struct packed {
    logic [7:0] pitch;
    logic [7:0] velocity;
    logic [7:0] duration;
    logic       legato;
  } note_t;

  typedef struct packed {
    logic              start;
    logic [7:0]        pitch;
    logic signed [9:0] top;
    logic signed [9:0] bottom;
  } fold_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] pitch;
  } fold_rsp_t;

endpackage

// ===== sv/cvs_ram.sv =====
module cvs_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cvs_fold.sv =====
module cvs_fold
  import cvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fold_req_t req_i,
  output fold_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    FoldIdle,
    FoldDown,
    FoldUp
  } fold_state_e;

  fold_state_e       state_q;
  logic [7:0]        val_q;
  logic [6:0]        steps_q;
  logic signed [9:0] top_q;
  logic signed [9:0] bot_q;
  logic              done_q;
  logic signed [9:0] val_ext;

  assign val_ext = signed'({2'b00, val_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FoldIdle;
      steps_q <= '0;
      done_q  <= 1'b0;
      val_q   <= '0;
      top_q   <= '0;
      bot_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        FoldIdle: begin
          if (req_i.start) begin
            val_q   <= req_i.pitch;
            top_q   <= req_i.top;
            bot_q   <= req_i.bottom;
            steps_q <= '0;
            state_q <= FoldDown;
          end
        end
        FoldDown: begin
          if (steps_q < FoldLimit && val_ext > top_q) begin
            val_q   <= val_q - OctaveStep;
            steps_q <= steps_q + 7'd1;
          end else begin
            steps_q <= '0;
            state_q <= FoldUp;
          end
        end
        FoldUp: begin
          if (steps_q < FoldLimit && val_ext < bot_q) begin
            val_q   <= val_q + OctaveStep;
            steps_q <= steps_q + 7'd1;
          end else begin
            done_q  <= 1'b1;
            state_q <= FoldIdle;
          end
        end
        default: state_q <= FoldIdle;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.pitch = val_q;

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= FoldLimit)
    else $error("fold step count past limit");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == FoldIdle)
    else $error("fold done while still folding");

endmodule

// ===== sv/chord_voicing_store.sv =====
// Chord store of up to MAX_NOTES notes held in one single-port-write, registered-read RAM.
// Start is taken while busy is low; each command returns one word on done_o for one
// cycle, which cannot be stalled. Set, unknown kinds, a read past the size, a clear to
// zero, an empty, shrinking or unchanged rescale and a normalize of under two notes answer
// from idle; a read passes the StRead state, clear writes each slot in turn, rescale
// reads and writes each added note, normalize scans for min/max, then folds each note
// by octave steps (at most 64 down and 64 up); all of it is paced by the single RAM
// port and the one-step-per-cycle fold unit. No clearing pass at reset.
module chord_voicing_store
  import cvs_pkg::*;
#(
  parameter int MAX_NOTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind_i,
  input  logic [7:0] index_i,
  input  logic [7:0] pitch_i,
  input  logic [7:0] velocity_i,
  input  logic [7:0] duration_i,
  input  logic       legato_i,
  input  logic [7:0] base_i,
  input  logic [7:0] size_i,
  output logic       done_o,
  output logic       found_o,
  output logic [7:0] out_pitch_o,
  output logic [7:0] out_velocity_o,
  output logic [7:0] out_duration_o,
  output logic       out_legato_o,
  output logic [3:0] chord_size_o
);

  localparam int IW = $clog2(MAX_NOTES);
  localparam int CW = $clog2(MAX_NOTES + 1);
  localparam logic [7:0]    MaxW = 8'(MAX_NOTES);
  localparam logic [CW-1:0] MaxC = CW'(MAX_NOTES);

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StClear,
    StScanRd,
    StScanAcc,
    StPrep,
    StFoldRd,
    StFoldLd,
    StFoldWait,
    StCopyRd,
    StCopyWr
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     limit_q;
  logic [CW-1:0]     ptr_q;
  logic [CW-1:0]     src_q;
  logic [7:0]        lift_q;
  logic [7:0]        lo_q;
  logic [7:0]        hi_q;
  logic [7:0]        base_q;
  logic signed [9:0] top_q;
  logic signed [9:0] bot_q;
  note_t             word_q;
  note_t             out_note_q;
  logic              done_q;
  logic              found_q;

  logic          accept;
  logic          hit;
  logic [CW-1:0] clamp;
  logic          ptr_last;
  logic          src_last;
  logic [9:0]    span;
  logic [7:0]    rng;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  note_t         ram_wdata;
  logic [IW-1:0] ram_raddr;
  note_t         ram_rdata;

  fold_req_t fold_req;
  fold_rsp_t fold_rsp;

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  assign hit      = index_i < 8'(count_q);
  assign clamp    = (size_i > MaxW) ? MaxC : CW'(size_i);
  assign ptr_last = (ptr_q + CW'(1)) == limit_q;
  assign src_last = (src_q + CW'(1)) == count_q;
  assign span     = 10'(hi_q) - 10'(lo_q) + 10'd1;
  assign rng      = span[8:1];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[IW-1:0];
    ram_wdata = '0;
    ram_raddr = ptr_q[IW-1:0];
    case (state_q)
      StIdle: begin
        ram_raddr = index_i[IW-1:0];
        ram_waddr = index_i[IW-1:0];
        ram_wdata = '{pitch: pitch_i, velocity: velocity_i, duration: duration_i,
                      legato: legato_i};
        ram_we    = accept && (kind_i == KindSet) && hit;
      end
      StClear: ram_we = 1'b1;
      StFoldWait: begin
        ram_we          = fold_rsp.done;
        ram_wdata       = word_q;
        ram_wdata.pitch = fold_rsp.pitch;
      end
      StCopyRd: ram_raddr = src_q[IW-1:0];
      StCopyWr: begin
        ram_we          = 1'b1;
        ram_wdata       = ram_rdata;
        ram_wdata.pitch = ram_rdata.pitch + lift_q;
      end
      default: ;
    endcase
  end

  assign fold_req.start  = (state_q == StFoldLd);
  assign fold_req.pitch  = ram_rdata.pitch;
  assign fold_req.top    = top_q;
  assign fold_req.bottom = bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      limit_q    <= '0;
      ptr_q      <= '0;
      src_q      <= '0;
      lift_q     <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      base_q     <= '0;
      top_q      <= '0;
      bot_q      <= '0;
      word_q     <= '0;
      out_note_q <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      out_note_q <= '0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            case (kind_i)
              KindClear: begin
                if (clamp == '0) begin
                  count_q <= '0;
                  done_q  <= 1'b1;
                end else begin
                  limit_q <= clamp;
                  ptr_q   <= '0;
                  state_q <= StClear;
                end
              end
              KindSet: done_q <= 1'b1;
              KindRead: begin
                if (hit) begin
                  state_q <= StRead;
                end else begin
                  done_q <= 1'b1;
                end
              end
              KindNorm: begin
                if (count_q < CW'(2)) begin
                  done_q <= 1'b1;
                end else begin
                  lo_q    <= MinSeed;
                  hi_q    <= '0;
                  ptr_q   <= '0;
                  limit_q <= count_q;
                  base_q  <= base_i;
                  state_q <= StScanRd;
                end
              end
              KindRescale: begin
                if (count_q == '0) begin
                  done_q <= 1'b1;
                end else if (size_i < 8'(count_q)) begin
                  count_q <= CW'(size_i);
                  done_q  <= 1'b1;
                end else if (clamp == count_q) begin
                  done_q <= 1'b1;
                end else begin
                  limit_q <= clamp;
                  ptr_q   <= count_q;
                  src_q   <= '0;
                  lift_q  <= OctaveStep;
                  state_q <= StCopyRd;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        StRead: begin
          done_q     <= 1'b1;
          found_q    <= 1'b1;
          out_note_q <= ram_rdata;
          state_q    <= StIdle;
        end
        StClear: begin
          ptr_q <= ptr_q + CW'(1);
          if (ptr_last) begin
            count_q <= limit_q;
            done_q  <= 1'b1;
            state_q <= StIdle;
          end
        end
        StScanRd: state_q <= StScanAcc;
        StScanAcc: begin
          if (ram_rdata.pitch < lo_q) begin
            lo_q <= ram_rdata.pitch;
          end
          if (ram_rdata.pitch > hi_q) begin
            hi_q <= ram_rdata.pitch;
          end
          if (ptr_last) begin
            state_q <= StPrep;
          end else begin
            ptr_q   <= ptr_q + CW'(1);
            state_q <= StScanRd;
          end
        end
        StPrep: begin
          top_q   <= signed'(10'(base_q) + 10'(rng));
          bot_q   <= signed'(10'(base_q) - 10'(rng));
          ptr_q   <= '0;
          state_q <= StFoldRd;
        end
        StFoldRd: state_q <= StFoldLd;
        StFoldLd: begin
          word_q  <= ram_rdata;
          state_q <= StFoldWait;
        end
        StFoldWait: begin
          if (fold_rsp.done) begin
            if (ptr_last) begin
              done_q  <= 1'b1;
              state_q <= StIdle;
            end else begin
              ptr_q   <= ptr_q + CW'(1);
              state_q <= StFoldRd;
            end
          end
        end
        StCopyRd: state_q <= StCopyWr;
        StCopyWr: begin
          ptr_q <= ptr_q + CW'(1);
          if (src_last) begin
            src_q  <= '0;
            lift_q <= lift_q + OctaveStep;
          end else begin
            src_q <= src_q + CW'(1);
          end
          if (ptr_last) begin
            count_q <= limit_q;
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else begin
            state_q <= StCopyRd;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  cvs_ram #(
    .WIDTH($bits(note_t)),
    .DEPTH(MAX_NOTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cvs_fold u_fold (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (fold_req),
    .rsp_o (fold_rsp)
  );

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign out_pitch_o    = out_note_q.pitch;
  assign out_velocity_o = out_note_q.velocity;
  assign out_duration_o = out_note_q.duration;
  assign out_legato_o   = out_note_q.legato;
  assign chord_size_o   = 4'(count_q);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while busy");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxC)
    else $error("note count past capacity");

  a_quiet_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !found_o && out_pitch_o == '0 && !out_legato_o)
    else $error("note fields driven without result word");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && state_q != StIdle |-> 8'(ptr_q) < MaxW)
    else $error("memory write past capacity");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import cvs_pkg::*;

  localparam int MaxNotes = 8;
  localparam int RandomCmds = 1600;
  localparam int PhaseLen = (RandomCmds + 2) / 3;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 40;
  localparam int ReportLimit = 10;
  localparam logic [2:0] KindSpareLo = KindRescale + 3'd1;
  localparam logic [2:0] KindSpareHi = '1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] index;
    logic [7:0] pitch;
    logic [7:0] velocity;
    logic [7:0] duration;
    logic       legato;
    logic [7:0] base;
    logic [7:0] size;
  } chord_cmd_t;

  typedef struct packed {
    logic       found;
    logic [7:0] pitch;
    logic [7:0] velocity;
    logic [7:0] duration;
    logic       legato;
    logic [3:0] chord_size;
  } chord_word_t;

  typedef struct packed {
    chord_cmd_t  cmd;
    logic        typed;
    chord_word_t word;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [2:0] kind_i;
  logic [7:0] index_i;
  logic [7:0] pitch_i;
  logic [7:0] velocity_i;
  logic [7:0] duration_i;
  logic       legato_i;
  logic [7:0] base_i;
  logic [7:0] size_i;
  logic       done_o;
  logic       found_o;
  logic [7:0] out_pitch_o;
  logic [7:0] out_velocity_o;
  logic [7:0] out_duration_o;
  logic       out_legato_o;
  logic [3:0] chord_size_o;

  note_t       chord_notes [MaxNotes];
  int          note_cnt;
  chord_word_t expected_words [$];
  int          kind_seen [8];
  int          words_checked;
  int          errors;
  int          stall_cycles;

  // directed commands: the word is typed in where it is obvious, else predicted
  dir_row_t dir_table [25] = '{
    '{'{KindRead,    0,   0,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 0}},
    '{'{KindRescale, 0,   0,   0,   0, 0,   0, 200}, 1, '{0,   0,   0,   0, 0, 0}},
    '{'{KindNorm,    0,   0,   0,   0, 0,  60,   0}, 1, '{0,   0,   0,   0, 0, 0}},
    '{'{KindClear,   0,   0,   0,   0, 0,   0, 255}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindRead,    7,   0,   0,   0, 0,   0,   0}, 1, '{1,   0,   0,   0, 0, 8}},
    '{'{KindRead,    8,   0,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindSet,     0, 255, 255, 255, 1,   0,   0}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindSet,   255,   1,   2,   3, 1,   0,   0}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindRead,    0,   0,   0,   0, 0,   0,   0}, 1, '{1, 255, 255, 255, 1, 8}},
    '{'{KindSet,     3,  60, 100,  50, 1,   0,   0}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindNorm,    0,   0,   0,   0, 0,   0,   0}, 0, '0},
    '{'{KindRead,    0,   0,   0,   0, 0,   0,   0}, 0, '0},
    '{'{KindNorm,    0,   0,   0,   0, 0, 255,   0}, 0, '0},
    '{'{KindRead,    3,   0,   0,   0, 0,   0,   0}, 0, '0},
    '{'{KindRescale, 0,   0,   0,   0, 0,   0,   2}, 1, '{0,   0,   0,   0, 0, 2}},
    '{'{KindRescale, 0,   0,   0,   0, 0,   0, 255}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindRead,    7,   0,   0,   0, 0,   0,   0}, 0, '0},
    '{'{KindSpareLo, 255, 255, 255, 255, 1, 255, 255}, 1, '{0,  0,   0,   0, 0, 8}},
    '{'{KindSpareHi, 0,   0,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 8}},
    '{'{KindClear,   0,   0,   0,   0, 0,   0,   2}, 1, '{0,   0,   0,   0, 0, 2}},
    '{'{KindSet,     0, 127,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 2}},
    '{'{KindSet,     1, 127,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 2}},
    '{'{KindNorm,    0,   0,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 2}},
    '{'{KindRead,    1,   0,   0,   0, 0,   0,   0}, 1, '{1, 127,   0,   0, 0, 2}},
    '{'{KindClear,   0,   0,   0,   0, 0,   0,   0}, 1, '{0,   0,   0,   0, 0, 0}}
  };

  chord_voicing_store #(
    .MAX_NOTES(MaxNotes)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .index_i       (index_i),
    .pitch_i       (pitch_i),
    .velocity_i    (velocity_i),
    .duration_i    (duration_i),
    .legato_i      (legato_i),
    .base_i        (base_i),
    .size_i        (size_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .out_pitch_o   (out_pitch_o),
    .out_velocity_o(out_velocity_o),
    .out_duration_o(out_duration_o),
    .out_legato_o  (out_legato_o),
    .chord_size_o  (chord_size_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic chord_word_t voice_command(input chord_cmd_t c);
    chord_word_t w;
    int lo, hi, half, top, bottom, v, n, target, steps;
    w = '0;
    case (c.kind)
      KindClear: begin
        target = (c.size > MaxNotes) ? MaxNotes : int'(c.size);
        note_cnt = target;
        for (int j = 0; j < target; j++) chord_notes[j] = '0;
      end
      KindSet: begin
        if (c.index < note_cnt)
          chord_notes[c.index] = '{c.pitch, c.velocity, c.duration, c.legato};
      end
      KindRead: begin
        if (c.index < note_cnt) begin
          w.found = 1'b1;
          w.pitch = chord_notes[c.index].pitch;
          w.velocity = chord_notes[c.index].velocity;
          w.duration = chord_notes[c.index].duration;
          w.legato = chord_notes[c.index].legato;
        end
      end
      KindNorm: begin
        if (note_cnt >= 2) begin
          lo = int'(MinSeed);
          hi = 0;
          for (int j = 0; j < note_cnt; j++) begin
            v = int'(chord_notes[j].pitch);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
          end
          half = (hi - lo + 1) / 2;
          top = int'(c.base) + half;
          bottom = int'(c.base) - half;
          for (int j = 0; j < note_cnt; j++) begin
            v = int'(chord_notes[j].pitch);
            // each fold gives up after FoldLimit octave steps
            for (steps = 0; steps < FoldLimit && v > top; steps++)
              v = (v - int'(OctaveStep)) & 255;
            for (steps = 0; steps < FoldLimit && v < bottom; steps++)
              v = (v + int'(OctaveStep)) & 255;
            chord_notes[j].pitch = 8'(v);
          end
        end
      end
      KindRescale: begin
        n = note_cnt;
        if (n != 0) begin
          if (c.size < n) begin
            note_cnt = c.size;
          end else begin
            target = (c.size > MaxNotes) ? MaxNotes : int'(c.size);
            for (int j = n; j < target; j++) begin
              chord_notes[j] = chord_notes[j % n];
              chord_notes[j].pitch = chord_notes[j % n].pitch
                                     + 8'(int'(OctaveStep) * (j / n));
            end
            note_cnt = target;
          end
        end
      end
      default: ;
    endcase
    w.chord_size = 4'(note_cnt);
    return w;
  endfunction

  function automatic chord_cmd_t random_command();
    chord_cmd_t c;
    int pick, span;
    c.index = $urandom_range(255);
    c.pitch = $urandom_range(255);
    c.velocity = $urandom_range(255);
    c.duration = $urandom_range(255);
    c.legato = $urandom_range(1);
    c.base = $urandom_range(255);
    c.size = $urandom_range(255);
    span = (note_cnt > 0) ? note_cnt - 1 : 0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      c.kind = KindClear;
      if ($urandom_range(99) < 85) c.size = $urandom_range(MaxNotes + 1);
    end else if (pick < 38) begin
      c.kind = KindSet;
      if ($urandom_range(99) < 85) c.index = $urandom_range(span);
      // clustered pitches keep the fold window narrow
      if ($urandom_range(1)) c.pitch = $urandom_range(96, 36);
    end else if (pick < 68) begin
      c.kind = KindRead;
      if ($urandom_range(99) < 85) c.index = $urandom_range(span);
    end else if (pick < 80) begin
      c.kind = KindNorm;
    end else if (pick < 95) begin
      c.kind = KindRescale;
      if ($urandom_range(99) < 70) c.size = $urandom_range(MaxNotes + 2);
    end else begin
      c.kind = $urandom_range(KindSpareHi, KindSpareLo);
    end
    return c;
  endfunction

  task automatic send_command(input chord_cmd_t c, input int idle_pct, input logic typed,
                              input chord_word_t typed_word);
    chord_word_t w;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    kind_i = c.kind;
    index_i = c.index;
    pitch_i = c.pitch;
    velocity_i = c.velocity;
    duration_i = c.duration;
    legato_i = c.legato;
    base_i = c.base;
    size_i = c.size;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    w = voice_command(c);
    expected_words.push_back(typed ? typed_word : w);
    kind_seen[c.kind]++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_fault(input string msg);
    errors++;
    if (errors <= ReportLimit) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    chord_word_t got, want;
    if (rst_ni && done_o) begin
      got = '{found_o, out_pitch_o, out_velocity_o, out_duration_o, out_legato_o,
              chord_size_o};
      words_checked++;
      if (expected_words.size() == 0) begin
        note_fault($sformatf("unexpected word: found %0d pitch %0d size %0d",
                             got.found, got.pitch, got.chord_size));
      end else begin
        want = expected_words.pop_front();
        if (got != want)
          note_fault($sformatf({"word mismatch: exp found %0d p %0d v %0d d %0d l %0d ",
                                "n %0d, got found %0d p %0d v %0d d %0d l %0d n %0d"},
                               want.found, want.pitch, want.velocity, want.duration,
                               want.legato, want.chord_size, got.found, got.pitch,
                               got.velocity, got.duration, got.legato, got.chord_size));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int idle_pct;
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = '0;
    index_i = '0;
    pitch_i = '0;
    velocity_i = '0;
    duration_i = '0;
    legato_i = 1'b0;
    base_i = '0;
    size_i = '0;
    note_cnt = 0;
    words_checked = 0;
    errors = 0;
    stall_cycles = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_table[r])
      send_command(dir_table[r].cmd, 35, dir_table[r].typed, dir_table[r].word);
    wait_for_drain();

    for (int i = 0; i < RandomCmds; i++) begin
      if (i != 0 && i % PhaseLen == 0) wait_for_drain();
      case (i / PhaseLen)
        0: idle_pct = 35;
        1: idle_pct = 56;
        default: idle_pct = 0;
      endcase
      send_command(random_command(), idle_pct, 1'b0, '0);
    end

    @(negedge clk_i);
    start = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d clears, %0d sets, %0d reads, %0d normalizes, %0d rescales, %0d spare",
             kind_seen[KindClear], kind_seen[KindSet], kind_seen[KindRead],
             kind_seen[KindNorm], kind_seen[KindRescale],
             kind_seen[5] + kind_seen[6] + kind_seen[7]);
    $display("%0d result words checked, %0d errors", words_checked, errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
